>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and constants for the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned DEPTH = 16;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_EMPTY_REMOVE = 2'd1;
	localparam logic [1:0] ST_FULL_DROP    = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
		logic signed [31:0] priority_req;
	} req_t;

	typedef struct packed {
		logic signed [31:0] head_value;
		logic signed [31:0] head_priority;
		logic               is_empty;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		logic   insert;
		logic   remove;
		entry_t new_entry;
	} ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; keeps it, takes the new entry or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_pkg::ctrl_t  ctrl,
	input  logic            is_head,
	input  spq_pkg::entry_t prev_entry,
	input  logic            prev_valid,
	input  logic            prev_keep,
	input  spq_pkg::entry_t next_entry,
	input  logic            next_valid,
	output spq_pkg::entry_t entry,
	output logic            valid,
	output logic            keep
);

	spq_pkg::entry_t entry_q;
	logic            valid_q;

	// The head stays ahead of a new entry of equal priority; others only when greater
	always_comb begin
		if (is_head) begin
			keep = valid_q && (entry_q.prio >= ctrl.new_entry.prio);
		end else begin
			keep = valid_q && (entry_q.prio > ctrl.new_entry.prio);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end else if (ctrl.remove) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && !keep) begin
			entry_q <= prev_keep ? ctrl.new_entry : prev_entry;
		end else if (ctrl.remove) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

>>> rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue kept in descending priority order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and raise start for one cycle per command; a command is
//   taken at a clock edge where start is high and busy is low. busy never
//   rises, so a command can be issued in every cycle.
//   Commands: insert (value, priority_req), remove head, or query.
//   Every command gives one result in the cycle after it is taken: done is high
//   for exactly one cycle and result carries the head value and priority
//   after the command (zero when empty), the empty flag and a status.
//   Throughput is one command per cycle: every cell compares its priority
//   with the new one in parallel and shifts in the same cycle.
//   Removing from an empty queue reports a status and changes nothing; an
//   insert into a full queue is dropped with a status.
//   Reset empties the queue and clears done. The receiver cannot stall: a
//   result not taken in its cycle is lost.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spq_pkg::req_t request,
	output logic          done,
	output spq_pkg::rsp_t result
);

	localparam int unsigned N = spq_pkg::DEPTH;

	spq_pkg::ctrl_t  ctrl;
	spq_pkg::entry_t cell_entry [N];
	logic [N-1:0]    cell_valid;
	logic [N-1:0]    cell_keep;
	logic            full;
	logic            empty;
	logic [1:0]      status_d;
	logic [1:0]      status_q;
	logic            done_q;

	assign busy  = 1'b0;
	assign full  = cell_valid[N-1];
	assign empty = !cell_valid[0];

	always_comb begin
		ctrl.insert              = 1'b0;
		ctrl.remove              = 1'b0;
		ctrl.new_entry.value     = request.value;
		ctrl.new_entry.prio      = request.priority_req;
		status_d                 = spq_pkg::ST_OK;
		if (start) begin
			unique case (request.command)
				spq_pkg::CMD_INSERT: begin
					if (full) begin
						status_d = spq_pkg::ST_FULL_DROP;
					end else begin
						ctrl.insert = 1'b1;
					end
				end
				spq_pkg::CMD_REMOVE: begin
					if (empty) begin
						status_d = spq_pkg::ST_EMPTY_REMOVE;
					end else begin
						ctrl.remove = 1'b1;
					end
				end
				default: begin
					// query and the unused code leave the queue as it is
				end
			endcase
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		spq_pkg::entry_t prev_entry;
		logic            prev_valid;
		logic            prev_keep;
		spq_pkg::entry_t next_entry;
		logic            next_valid;

		if (i == 0) begin : g_first
			assign prev_entry = ctrl.new_entry;
			assign prev_valid = 1'b1;
			assign prev_keep  = 1'b1;
		end else begin : g_mid
			assign prev_entry = cell_entry[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_keep  = cell_keep[i-1];
		end

		if (i == N - 1) begin : g_last
			assign next_entry = cell_entry[i];
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_entry = cell_entry[i+1];
			assign next_valid = cell_valid[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.is_head    (i == 0),
			.prev_entry (prev_entry),
			.prev_valid (prev_valid),
			.prev_keep  (prev_keep),
			.next_entry (next_entry),
			.next_valid (next_valid),
			.entry      (cell_entry[i]),
			.valid      (cell_valid[i]),
			.keep       (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= spq_pkg::ST_OK;
		end else begin
			done_q   <= start;
			status_q <= status_d;
		end
	end

	// The head cell already holds the state after the transfer
	assign done                 = done_q;
	assign result.head_value    = empty ? 32'sd0 : cell_entry[0].value;
	assign result.head_priority = empty ? 32'sd0 : cell_entry[0].prio;
	assign result.is_empty      = empty;
	assign result.status        = status_q;

endmodule
